// File: design/lit_pkg.sv
// Shared types and constants for the linear interpolation table.
// Used by lit_div and linear_interpolation_table; depends on nothing else.
`timescale 1ns / 1ps

package lit_pkg;

  localparam int DATA_W     = 32;   // Q16.16 sample width
  localparam int IDX_W      = 8;    // load index field width
  localparam int PU_W       = 9;    // points_used register width
  localparam int MIN_POINTS = 2;    // smallest usable grid
  localparam int PROD_W     = 2 * DATA_W;

  localparam int S_TDATA_W  = IDX_W + 3 * DATA_W;  // 104, already whole bytes
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = DATA_W;
  localparam int M_TUSER_W  = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_PROBE,
    ST_STEP,
    ST_HIT,
    ST_PREV,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_START,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// File: design/lit_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lit_pkg. The caller guarantees the quotient fits in DATA_W bits.
`timescale 1ns / 1ps

module lit_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lit_pkg::PROD_W-1:0]    dividend,
  input  logic [lit_pkg::DATA_W-1:0]    divisor,
  output logic                          done,
  output logic [lit_pkg::DATA_W-1:0]    quotient
);
  import lit_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              fits;

  // Bring in the next dividend bit and try one subtraction.
  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[PROD_W-1:DATA_W];
      quo <= dividend[DATA_W-1:0];
    end else if (busy) begin
      rem <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// File: design/linear_interpolation_table.sv
// Top level of the piecewise linear interpolation table.
// Depends on lit_pkg and lit_div.
`timescale 1ns / 1ps

// The block keeps a grid of (x, y) points in signed Q16.16 and answers
// interpolation queries against it. Input transactions arrive on the s_
// stream: s_tuser selects a load (0) or a query (1). A load writes one grid
// point and produces no output transaction. A query produces exactly one
// output transaction on the m_ stream carrying the value and the
// out_of_range and exact_hit flags.
// Queries run through a small sequencer around one grid memory port, one
// shared multiplier and a bit-serial divider. The binary search makes at most
// ceil(log2(points_used+1)) probes (nine at 256 points). An out-of-span
// result skips the search, and an exact hit skips the interpolation, which
// adds operand setup, the two products and their sum, and the division; the
// divider dominates. The next transaction is taken once the sequencer is idle.
// The block takes one input transaction at a time: s_tready is high only
// when the sequencer is idle. A finished result sits in the output register
// until the receiver takes it, and the next transaction may be accepted
// meanwhile; a later query waits at its end until that register is free.
// Reset clears the sequencer, the output valid and sets points_used to 2.
// The grid memory is not cleared: each entry must be loaded before use.
// Write points_used (cfg_we/cfg_wdata) only while idle; the block does not enforce it.
module linear_interpolation_table #(
  parameter int GRID_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata, low bit up: load_index[7:0], load_x[31:0], load_y[31:0], query_x[31:0]
  input  logic [lit_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: command (0 load, 1 query)
  input  logic [lit_pkg::S_TUSER_W-1:0]   s_tuser,
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: value[31:0]
  output logic [lit_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser, low bit up: out_of_range, exact_hit
  output logic [lit_pkg::M_TUSER_W-1:0]   m_tuser,
  // points_used register write.
  input  logic                            cfg_we,
  input  logic [lit_pkg::PU_W-1:0]        cfg_wdata
);
  import lit_pkg::*;

  localparam int AW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
  localparam int CW = $clog2(GRID_DEPTH + 1);
  localparam int NW = (CW > PU_W) ? CW : PU_W;

  // Input field unpacking.
  logic              cmd;
  logic [IDX_W-1:0]  load_index;
  logic [DATA_W-1:0] load_x;
  logic [DATA_W-1:0] load_y;
  logic [DATA_W-1:0] query_x;

  assign cmd        = s_tuser[0];
  assign load_index = s_tdata[IDX_W-1:0];
  assign load_x     = s_tdata[IDX_W +: DATA_W];
  assign load_y     = s_tdata[IDX_W + DATA_W +: DATA_W];
  assign query_x    = s_tdata[IDX_W + 2 * DATA_W +: DATA_W];

  // Grid memories, one shared address, registered read data.
  logic [DATA_W-1:0] x_mem [GRID_DEPTH];
  logic [DATA_W-1:0] y_mem [GRID_DEPTH];
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic signed [DATA_W-1:0] x_rd;
  logic signed [DATA_W-1:0] y_rd;

  state_t state, state_next;

  logic [PU_W-1:0]   points_used;
  logic signed [DATA_W-1:0] q;
  logic [CW-1:0]     n;
  logic [AW-1:0]     n_m1;
  logic              below;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic signed [DATA_W-1:0] x1;
  logic signed [DATA_W-1:0] y1;
  logic signed [DATA_W-1:0] y0;
  logic signed [DATA_W:0]   p;
  logic signed [DATA_W:0]   r;
  logic [DATA_W-1:0] d;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] acc;
  logic              neg;

  logic [DATA_W-1:0] res_value;
  logic              res_oor;
  logic              res_exact;

  logic              in_accept;
  logic              load_ok;
  logic [NW-1:0]     pu_ext;
  logic [NW-1:0]     n_clamp;
  logic [CW:0]       lo_hi_sum;
  logic [CW-1:0]     mid;
  logic [CW-1:0]     lo_fix;
  logic              search_open;
  logic              q_lt_x;
  logic              q_gt_x;
  logic              q_eq_x;
  logic              out_free;
  logic              mul_sel_second;
  logic signed [DATA_W:0]     mul_a;
  logic signed [DATA_W-1:0]   mul_b;
  logic signed [PROD_W:0]     mul_full;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [PROD_W-1:0] acc_mag;
  logic signed [DATA_W:0]     x1_ext;
  logic signed [DATA_W:0]     q_ext;
  logic signed [DATA_W:0]     x0_ext;
  logic signed [DATA_W:0]     d_full;

  assign in_accept = s_tvalid && s_tready;
  assign load_ok   = NW'(load_index) < NW'(GRID_DEPTH);
  assign wr_addr   = AW'(load_index);
  assign mem_we    = in_accept && (cmd == CMD_LOAD) && load_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[wr_addr] <= load_x;
      y_mem[wr_addr] <= load_y;
    end
    x_rd <= x_mem[mem_addr];
    y_rd <= y_mem[mem_addr];
  end

  // Grid size in use, clamped to the legal span.
  assign pu_ext  = NW'(points_used);
  assign n_clamp = (pu_ext < NW'(MIN_POINTS)) ? NW'(MIN_POINTS) :
                   (pu_ext > NW'(GRID_DEPTH)) ? NW'(GRID_DEPTH) : pu_ext;

  // Binary search helpers.
  assign lo_hi_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid         = lo_hi_sum[CW:1];
  assign search_open = lo < hi;
  assign lo_fix      = (lo >= n) ? (n - CW'(1)) : lo;

  // Comparisons of q against the read x, shared by the span test and the exact-hit check.
  assign q_lt_x = q < x_rd;
  assign q_gt_x = q > x_rd;
  assign q_eq_x = q == x_rd;

  assign out_free = !m_tvalid || m_tready;

  // Operand setup for the interpolation: p = x[i] - q, r = q - x[i-1].
  assign x1_ext = {x1[DATA_W-1], x1};
  assign q_ext  = {q[DATA_W-1], q};
  assign x0_ext = {x_rd[DATA_W-1], x_rd};
  assign d_full = x1_ext - x0_ext;

  // Shared multiplier: p*y0 first, then r*y1.
  assign mul_a    = mul_sel_second ? r : p;
  assign mul_b    = mul_sel_second ? y1 : y0;
  assign mul_full = mul_a * mul_b;

  assign acc_mag = acc[PROD_W-1] ? PROD_W'(-acc) : PROD_W'(acc);

  lit_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_mag),
    .divisor  (d),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && (cmd == CMD_QUERY)) begin
          state_next = ST_FIRST;
        end
      end
      ST_FIRST:     state_next = ST_LAST;
      ST_LAST: begin
        if (below || q_gt_x) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE:     state_next = search_open ? ST_STEP : ST_HIT;
      ST_STEP:      state_next = ST_PROBE;
      ST_HIT: begin
        if ((lo == '0) || q_eq_x) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PREV;
        end
      end
      ST_PREV:      state_next = ST_MUL0;
      ST_MUL0:      state_next = ST_MUL1;
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready       = 1'b0;
    mem_addr       = '0;
    mul_sel_second = 1'b0;
    div_start      = 1'b0;
    case (state)
      ST_IDLE:      s_tready = 1'b1;
      ST_FIRST:     mem_addr = n_m1;
      ST_PROBE:     mem_addr = search_open ? AW'(mid) : AW'(lo_fix);
      ST_HIT:       mem_addr = AW'(lo - CW'(1));
      ST_MUL1:      mul_sel_second = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      default: begin
        mem_addr = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      points_used <= PU_W'(MIN_POINTS);
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        points_used <= cfg_wdata;
      end
      if ((state == ST_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          q    <= query_x;
          n    <= CW'(n_clamp);
          n_m1 <= AW'(n_clamp - NW'(1));
        end
      end
      ST_FIRST: begin
        // x[0] is on the read port now.
        below <= q_lt_x;
      end
      ST_LAST: begin
        lo        <= '0;
        hi        <= n;
        res_value <= '0;
        res_oor   <= 1'b1;
        res_exact <= 1'b0;
      end
      ST_PROBE: begin
        if (!search_open) begin
          lo <= lo_fix;
        end
      end
      ST_STEP: begin
        if (x_rd < q) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      ST_HIT: begin
        x1        <= x_rd;
        y1        <= y_rd;
        res_value <= y_rd;
        res_oor   <= 1'b0;
        res_exact <= 1'b1;
      end
      ST_PREV: begin
        p         <= x1_ext - q_ext;
        r         <= q_ext - x0_ext;
        d         <= d_full[DATA_W-1:0];
        y0        <= y_rd;
        res_exact <= 1'b0;
      end
      ST_MUL0:      prod <= mul_full[PROD_W-1:0];
      ST_MUL1: begin
        prod <= mul_full[PROD_W-1:0];
        acc  <= prod;
      end
      ST_MUL2:      acc <= acc + prod;
      ST_DIV_START: neg <= acc[PROD_W-1];
      ST_DIV: begin
        if (div_done) begin
          res_value <= neg ? (-div_quo) : div_quo;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= res_value;
          m_tuser <= {res_exact, res_oor};
        end
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

endmodule
